FILE: hdl/audio_channel_matrix_mixer_assert.svh
// Assertion macros for the channel matrix mixer.
// Used by the top level; no other dependencies.
`ifndef AUDIO_CHANNEL_MATRIX_MIXER_ASSERT_SVH
`define AUDIO_CHANNEL_MATRIX_MIXER_ASSERT_SVH
`ifndef SYNTH
// Whenever cond holds, prop must hold in the same cycle
`define ACMM_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: label");
// Whenever cond holds, prop must hold in the next cycle
`define ACMM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: label");
`else
`define ACMM_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ACMM_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

FILE: hdl/acmm_pkg.sv
// Shared constants, payload types and helpers of the channel matrix mixer.
// No dependencies.
package acmm_pkg;

    // Channel counts
    localparam int IN_CHANNELS   = 4;
    localparam int OUT_CHANNELS  = 4;
    localparam int SAMPLE_FIELDS = 4;
    localparam int MAX_RESULTS   = 4;
    localparam int RES_COUNT     = (OUT_CHANNELS < MAX_RESULTS) ? OUT_CHANNELS : MAX_RESULTS;

    // Index widths
    localparam int IN_IDX_W  = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
    localparam int OUT_IDX_W = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
    localparam int CH_W      = (RES_COUNT > 1) ? $clog2(RES_COUNT) : 1;

    // Datapath widths
    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 16;
    localparam int PROD_W   = SAMPLE_W + GAIN_W;
    localparam int SUM_W    = PROD_W + $clog2(IN_CHANNELS) + 1;
    localparam int FRAC_DROP = 12;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (FRAC_DROP - 1));
    localparam logic signed [SUM_W-1:0] SAT_HI     = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO     = -SUM_W'(1 << (SAMPLE_W - 1));

    // Command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Request type codes
    localparam logic REQ_MIX        = 1'b0;
    localparam logic REQ_GAIN_WRITE = 1'b1;

    typedef struct packed {
        logic                       req_type;
        logic signed [SAMPLE_W-1:0] sample_0;
        logic signed [SAMPLE_W-1:0] sample_1;
        logic signed [SAMPLE_W-1:0] sample_2;
        logic signed [SAMPLE_W-1:0] sample_3;
        logic [1:0]                 gain_src;
        logic [1:0]                 gain_dst;
        logic signed [GAIN_W-1:0]   gain_value;
    } acmm_req_t;

    typedef struct packed {
        logic [1:0]                 out_channel;
        logic signed [SAMPLE_W-1:0] mixed_sample;
        logic                       last_channel;
    } acmm_res_t;

    // Classified command passed from front to back
    typedef struct packed {
        logic                                 is_write;
        logic [OUT_IDX_W-1:0]                 dst;
        logic [IN_IDX_W-1:0]                  src;
        logic [GAIN_W-1:0]                    gain;
        logic [IN_CHANNELS-1:0][SAMPLE_W-1:0] samples;
    } acmm_cmd_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } acmm_qstat_t;

    // Sample of input channel idx; channels without a field read as zero
    function automatic logic [SAMPLE_W-1:0] sample_field(acmm_req_t req, int idx);
        logic [SAMPLE_W-1:0] val;
        val = '0;
        case (idx)
            0:       val = req.sample_0;
            1:       val = req.sample_1;
            2:       val = req.sample_2;
            3:       val = req.sample_3;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

FILE: hdl/acmm_queue.sv
// Small FIFO of classified commands between the front and back parts.
// Depends on acmm_pkg.
module acmm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  acmm_pkg::acmm_cmd_t push_cmd,
    input  logic                pop,
    output acmm_pkg::acmm_cmd_t head_cmd,
    output acmm_pkg::acmm_qstat_t qstat
);

    acmm_pkg::acmm_cmd_t              mem [acmm_pkg::QUEUE_DEPTH];
    logic [acmm_pkg::Q_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [acmm_pkg::Q_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [acmm_pkg::Q_CNT_W-1:0]     count_reg, count_next;

    // Storage write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_cmd    = mem[rd_ptr_reg];
    assign qstat.full  = (count_reg == acmm_pkg::Q_CNT_W'(acmm_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

endmodule

FILE: hdl/acmm_front.sv
// Front part: accepts requests, drops out-of-range gain writes, and
// registers a classified command for the queue. Depends on acmm_pkg.
module acmm_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  acmm_pkg::acmm_req_t   req_data,
    input  acmm_pkg::acmm_qstat_t qstat,
    output logic                  push,
    output acmm_pkg::acmm_cmd_t   push_cmd
);

    logic                front_valid_reg, front_valid_next;
    acmm_pkg::acmm_cmd_t front_cmd_reg;
    acmm_pkg::acmm_cmd_t cmd_class;
    logic                accept;
    logic                keep;

    // Classify the incoming request
    always_comb
    begin
        cmd_class.is_write = (req_data.req_type == acmm_pkg::REQ_GAIN_WRITE);
        cmd_class.dst      = acmm_pkg::OUT_IDX_W'(req_data.gain_dst);
        cmd_class.src      = acmm_pkg::IN_IDX_W'(req_data.gain_src);
        cmd_class.gain     = req_data.gain_value;
        for (int i = 0; i < acmm_pkg::IN_CHANNELS; i++)
        begin
            cmd_class.samples[i] = acmm_pkg::sample_field(req_data, i);
        end
        // A gain write outside the table changes nothing and is dropped here
        keep = !cmd_class.is_write ||
               ((int'(req_data.gain_src) < acmm_pkg::IN_CHANNELS) &&
                (int'(req_data.gain_dst) < acmm_pkg::OUT_CHANNELS));
    end

    assign req_stall = front_valid_reg && qstat.full;
    assign accept    = req_valid && !req_stall;
    assign push      = front_valid_reg && !qstat.full;
    assign push_cmd  = front_cmd_reg;

    // Holding register
    always_comb
    begin
        front_valid_next = front_valid_reg && !push;
        if (accept && keep)
        begin
            front_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            front_cmd_reg <= cmd_class;
        end
    end

endmodule

FILE: hdl/acmm_back.sv
// Back part: holds the gain table, steps through output channels of each
// frame and runs the multiply, sum and saturate pipeline. Depends on acmm_pkg.
module acmm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  acmm_pkg::acmm_cmd_t   head_cmd,
    input  acmm_pkg::acmm_qstat_t qstat,
    output logic                  pop,
    output logic                  mix_valid,
    input  logic                  mix_stall,
    output acmm_pkg::acmm_res_t   mix_data
);

    localparam int NI = acmm_pkg::IN_CHANNELS;
    localparam int NO = acmm_pkg::OUT_CHANNELS;

    logic signed [acmm_pkg::GAIN_W-1:0] gain_reg [NO][NI];

    logic [acmm_pkg::CH_W-1:0] chan_reg, chan_next;
    logic                      adv;
    logic                      issue;
    logic                      wr_en;
    logic                      chan_last;

    logic                                s1_valid_reg;
    logic [acmm_pkg::CH_W-1:0]           s1_chan_reg;
    logic                                s1_last_reg;
    logic signed [acmm_pkg::PROD_W-1:0]  s1_prod_reg [NI];
    logic signed [acmm_pkg::PROD_W-1:0]  s1_prod_next [NI];

    logic                                s2_valid_reg;
    logic [acmm_pkg::CH_W-1:0]           s2_chan_reg;
    logic                                s2_last_reg;
    logic signed [acmm_pkg::SUM_W-1:0]   s2_sum_reg, s2_sum_next;

    logic                                out_valid_reg;
    acmm_pkg::acmm_res_t                 out_res_reg, out_res_next;
    logic signed [acmm_pkg::SUM_W-1:0]   rnd;

    // Issue control: writes retire at once, frames issue channel by channel while the output advances
    assign adv       = !out_valid_reg || !mix_stall;
    assign chan_last = (chan_reg == acmm_pkg::CH_W'(acmm_pkg::RES_COUNT - 1));
    assign wr_en     = !qstat.empty && head_cmd.is_write;
    assign issue     = !qstat.empty && !head_cmd.is_write && adv;
    assign pop       = wr_en || (issue && chan_last);

    always_comb
    begin
        chan_next = chan_reg;
        if (issue)
        begin
            chan_next = chan_last ? '0 : chan_reg + 1'b1;
        end
    end

    // Gain table, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int o = 0; o < NO; o++)
            begin
                for (int i = 0; i < NI; i++)
                begin
                    gain_reg[o][i] <= '0;
                end
            end
        end
        else if (wr_en)
        begin
            gain_reg[head_cmd.dst][head_cmd.src] <= head_cmd.gain;
        end
    end

    // One product per input lane for the current output channel
    always_comb
    begin
        for (int i = 0; i < NI; i++)
        begin
            s1_prod_next[i] = acmm_pkg::PROD_W'($signed(head_cmd.samples[i])) *
                              acmm_pkg::PROD_W'(gain_reg[acmm_pkg::OUT_IDX_W'(chan_reg)][i]);
        end
    end

    // Sum of the lane products
    always_comb
    begin
        s2_sum_next = '0;
        for (int i = 0; i < NI; i++)
        begin
            s2_sum_next = s2_sum_next + acmm_pkg::SUM_W'(s1_prod_reg[i]);
        end
    end

    // Round half up to Q1.23, then clamp
    always_comb
    begin
        rnd = (s2_sum_reg + acmm_pkg::ROUND_HALF) >>> acmm_pkg::FRAC_DROP;
        out_res_next.out_channel  = 2'(s2_chan_reg);
        out_res_next.last_channel = s2_last_reg;
        if (rnd > acmm_pkg::SAT_HI)
        begin
            out_res_next.mixed_sample = acmm_pkg::SAMPLE_W'(acmm_pkg::SAT_HI);
        end
        else if (rnd < acmm_pkg::SAT_LO)
        begin
            out_res_next.mixed_sample = acmm_pkg::SAMPLE_W'(acmm_pkg::SAT_LO);
        end
        else
        begin
            out_res_next.mixed_sample = acmm_pkg::SAMPLE_W'(rnd);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            chan_reg <= chan_next;
            if (adv)
            begin
                s1_valid_reg  <= issue;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_chan_reg <= chan_reg;
            s1_last_reg <= chan_last;
            for (int i = 0; i < NI; i++)
            begin
                s1_prod_reg[i] <= s1_prod_next[i];
            end
            s2_chan_reg <= s1_chan_reg;
            s2_last_reg <= s1_last_reg;
            s2_sum_reg  <= s2_sum_next;
            out_res_reg <= out_res_next;
        end
    end

    assign mix_valid = out_valid_reg;
    assign mix_data  = out_res_reg;

endmodule

FILE: hdl/audio_channel_matrix_mixer.sv
// Channel matrix mixer: a mix request yields one result per output channel.
// Requests pass the front holding register and the queue; the back part then
// issues one output channel per cycle, unless mix_stall holds the output, through
// its product, sum and round/clamp registers. Gain writes retire as soon as they
// reach the queue head. Reset clears the gain table to zero and empties all stages.
// Depends on acmm_pkg, acmm_front, acmm_queue, acmm_back and the assert header.
`include "audio_channel_matrix_mixer_assert.svh"

module audio_channel_matrix_mixer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  acmm_pkg::acmm_req_t req_data,
    output logic                mix_valid,
    input  logic                mix_stall,
    output acmm_pkg::acmm_res_t mix_data
);

    logic                  q_push;
    logic                  q_pop;
    acmm_pkg::acmm_cmd_t   push_cmd;
    acmm_pkg::acmm_cmd_t   head_cmd;
    acmm_pkg::acmm_qstat_t qstat;
    logic                  last_mark_ok;

    acmm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .qstat     (qstat),
        .push      (q_push),
        .push_cmd  (push_cmd)
    );

    acmm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .qstat    (qstat)
    );

    acmm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .qstat     (qstat),
        .pop       (q_pop),
        .mix_valid (mix_valid),
        .mix_stall (mix_stall),
        .mix_data  (mix_data)
    );

    assign last_mark_ok = mix_data.last_channel ==
                          (mix_data.out_channel == 2'(acmm_pkg::RES_COUNT - 1));

    // Queue never written when full nor read when empty
    `ACMM_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, q_push, !qstat.full)
    `ACMM_ASSERT_IMPLIES(a_no_underflow, clk, rst_n, q_pop, !qstat.empty)
    // The last-channel mark sits on the final channel of the frame only
    `ACMM_ASSERT_IMPLIES(a_last_mark, clk, rst_n, mix_valid, last_mark_ok)
    // A full queue stays full until the back part pops
    `ACMM_ASSERT_NEXT(a_full_holds, clk, rst_n, qstat.full && !q_pop, qstat.full)

endmodule
